// ----- rtl/core/u8kc_pkg.sv -----
// shared constants and handshake structs for the utf-8 key code allocator
// no dependencies; imported by u8kc_ctrl, u8kc_dpath and utf8_keycode_allocator
package u8kc_pkg;

  localparam int TABLE_SLOTS = 246;
  localparam int SLOT_W      = 8;
  localparam int CP_W        = 21;

  // utf-8 byte classes
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_TAG   = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_TAG  = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_TAG  = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_TAG  = 8'hF0;

  typedef struct packed {
    logic take;     // input request accepted this cycle
    logic search;   // table search in progress
  } cmd_t;

  typedef struct packed {
    logic dec_emit; // accepted byte completes a code point
    logic dec_eom;  // accepted byte is the terminating nul
    logic hit;      // search found the code point
    logic miss;     // search ended without a match
  } status_t;

endpackage

// ----- rtl/core/utf8_keycode_allocator.sv -----
// Streaming utf-8 decoder that gives each distinct code point a key code (its slot in a
// 246-entry table plus one). One byte is taken per request; bytes that finish no code point
// leave the input ready for the next byte. A completed code point is compared against the table
// one stored entry per cycle through the table's registered read port; its result is then held
// until out_ready, and the next byte is taken after the result leaves. A nul byte gives an end
// marker in the next cycle and empties the table. When the table is full, a new code point
// starts a fresh chunk in slot 0.
// top level; depends on u8kc_pkg, u8kc_ctrl and u8kc_dpath
module utf8_keycode_allocator (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 text_byte,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [u8kc_pkg::CP_W-1:0]  code_point,
  output logic [7:0]                 key_code,
  output logic                       new_entry,
  output logic                       new_chunk,
  output logic                       end_of_message
);
  import u8kc_pkg::*;

  cmd_t    cmd;
  status_t status;

  u8kc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  u8kc_dpath u_dpath (
    .clk            (clk),
    .rst            (rst),
    .text_byte      (text_byte),
    .cmd            (cmd),
    .status         (status),
    .code_point     (code_point),
    .key_code       (key_code),
    .new_entry      (new_entry),
    .new_chunk      (new_chunk),
    .end_of_message (end_of_message)
  );

endmodule

// ----- rtl/core/u8kc_ctrl.sv -----
// controller state machine: accept, search, hold result
// depends on u8kc_pkg for cmd_t and status_t
module u8kc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  u8kc_pkg::status_t  status,
  output u8kc_pkg::cmd_t     cmd
);
  import u8kc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_OUT    = 3'b100
  } state_t;

  state_t state, state_next;
  logic   take;
  logic   search;

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_OUT);
  assign take      = (state == ST_IDLE) && in_valid;
  assign search    = (state == ST_SEARCH);
  assign cmd       = {take, search};

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (take) begin
          if (status.dec_eom) begin
            state_next = ST_OUT;
          end else if (status.dec_emit) begin
            state_next = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        if (status.hit || status.miss) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- rtl/core/u8kc_dpath.sv -----
// datapath: utf-8 decode registers, distinct code point table, search and result
// depends on u8kc_pkg for constants and the cmd_t / status_t structs
module u8kc_dpath (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [7:0]                 text_byte,
  input  u8kc_pkg::cmd_t             cmd,
  output u8kc_pkg::status_t          status,
  output logic [u8kc_pkg::CP_W-1:0]  code_point,
  output logic [7:0]                 key_code,
  output logic                       new_entry,
  output logic                       new_chunk,
  output logic                       end_of_message
);
  import u8kc_pkg::*;

  logic [1:0]        pending, pending_next;
  logic [CP_W-1:0]   partial, partial_next;
  logic [CP_W-1:0]   dec_cp;
  logic [CP_W-1:0]   cp_reg;
  logic [SLOT_W-1:0] slots_used;
  logic [SLOT_W-1:0] rd_idx;
  logic [SLOT_W-1:0] cmp_idx;
  logic              cmp_valid;
  logic [CP_W-1:0]   rd_data;
  logic [SLOT_W-1:0] ins_slot;
  logic              is_cont;
  logic              dec_emit;
  logic              dec_eom;
  logic              hit;
  logic              miss;

  logic [CP_W-1:0]   table_mem [TABLE_SLOTS];

  // byte decode
  always_comb begin
    is_cont      = (text_byte & CONT_MASK) == CONT_TAG;
    pending_next = pending;
    partial_next = partial;
    dec_cp       = '0;
    dec_emit     = 1'b0;
    dec_eom      = 1'b0;
    if (pending != 2'd0 && is_cont) begin
      partial_next = {partial[CP_W-7:0], text_byte[5:0]};
      pending_next = pending - 2'd1;
      if (pending == 2'd1) begin
        dec_emit = 1'b1;
        dec_cp   = partial_next;
      end
    end else begin
      // a bad continuation drops the sequence and is handled as a lead
      pending_next = 2'd0;
      partial_next = '0;
      if (text_byte == 8'd0) begin
        dec_eom = 1'b1;
      end else if (!text_byte[7]) begin
        dec_emit = 1'b1;
        dec_cp   = CP_W'(text_byte);
      end else if ((text_byte & LEAD2_MASK) == LEAD2_TAG) begin
        partial_next = CP_W'(text_byte[4:0]);
        pending_next = 2'd1;
      end else if ((text_byte & LEAD3_MASK) == LEAD3_TAG) begin
        partial_next = CP_W'(text_byte[3:0]);
        pending_next = 2'd2;
      end else if ((text_byte & LEAD4_MASK) == LEAD4_TAG) begin
        partial_next = CP_W'(text_byte[2:0]);
        pending_next = 2'd3;
      end
    end
  end

  // search results, one entry compared per cycle behind the registered read
  assign hit  = cmd.search && cmp_valid && (rd_data == cp_reg);
  assign miss = cmd.search && !hit &&
                ((slots_used == '0) ||
                 (cmp_valid && cmp_idx == SLOT_W'(slots_used - 8'd1)));

  assign status = {dec_emit, dec_eom, hit, miss};

  // full table wraps to a fresh chunk
  assign ins_slot = (slots_used >= SLOT_W'(TABLE_SLOTS)) ? '0 : slots_used;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending    <= 2'd0;
      partial    <= '0;
      slots_used <= '0;
      cmp_valid  <= 1'b0;
    end else begin
      if (cmd.take) begin
        pending   <= pending_next;
        partial   <= partial_next;
        cmp_valid <= 1'b0;
        if (dec_eom) begin
          slots_used <= '0;
        end
      end else if (cmd.search) begin
        cmp_valid <= (rd_idx < slots_used) && !hit && !miss;
        if (miss) begin
          slots_used <= ins_slot + 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      cp_reg <= dec_cp;
      rd_idx <= '0;
      if (dec_eom) begin
        code_point     <= '0;
        key_code       <= '0;
        new_entry      <= 1'b0;
        new_chunk      <= 1'b0;
        end_of_message <= 1'b1;
      end
    end else if (cmd.search) begin
      if (rd_idx < slots_used) begin
        rd_data <= table_mem[rd_idx];
        cmp_idx <= rd_idx;
        rd_idx  <= rd_idx + 8'd1;
      end
      if (hit) begin
        code_point     <= cp_reg;
        key_code       <= cmp_idx + 8'd1;
        new_entry      <= 1'b0;
        new_chunk      <= 1'b0;
        end_of_message <= 1'b0;
      end else if (miss) begin
        table_mem[ins_slot] <= cp_reg;
        code_point          <= cp_reg;
        key_code            <= ins_slot + 8'd1;
        new_entry           <= 1'b1;
        new_chunk           <= (ins_slot == '0);
        end_of_message      <= 1'b0;
      end
    end
  end

endmodule
